// ----- rtl/mngm_pkg.sv -----
// Shared types and constants of the memoized nearest glyph matcher.
// Used by every module under rtl; depends on nothing.
package mngm_pkg;

    localparam int NCOMP          = 6;
    localparam int NPAIR          = NCOMP / 2;
    localparam int COMP_W         = 18;
    localparam int GLYPH_W        = 8;
    localparam int MODE_W         = 2;
    localparam int INDEX_W        = 7;
    localparam int SQ_W           = 36;
    localparam int PAIR_W         = SQ_W + 1;
    localparam int DIST_W         = 39;
    localparam int KEY_MAX_W      = 30;
    localparam int EPOCH_W        = 4;

    localparam int CHAR_COUNT_DEF = 96;
    localparam int CACHE_BITS_DEF = 20;
    localparam int LEVEL_BITS_DEF = 5;

    localparam logic [16:0]        ONE_Q16    = 17'd65536;
    localparam int                 HALF_Q16   = 32768;
    localparam logic [GLYPH_W-1:0] SPACE_CODE = 8'h20;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MATCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    typedef logic [NCOMP-1:0][COMP_W-1:0] shape_t;

    typedef struct packed {
        logic [GLYPH_W-1:0] code;
        shape_t             comps;
    } entry_t;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [GLYPH_W-1:0] code;
    } cache_line_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } cache_cmd_t;

    typedef struct packed {
        logic clear;
        logic valid;
        logic last;
    } dist_ctl_t;

endpackage

// ----- rtl/mngm_table.sv -----
// Glyph table memory: one entry (code and six components) per word.
// Synchronous write, registered read. Depends on mngm_pkg.
module mngm_table
    import mngm_pkg::*;
#(
    parameter int CHAR_COUNT = CHAR_COUNT_DEF,
    localparam int TIDX_W = (CHAR_COUNT > 1) ? $clog2(CHAR_COUNT) : 1
)(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [TIDX_W-1:0] wr_addr,
    input  entry_t            wr_data,
    input  logic              rd_en,
    input  logic [TIDX_W-1:0] rd_addr,
    output entry_t            rd_data
);

    entry_t mem [CHAR_COUNT];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/mngm_cache.sv -----
// Answer cache memory: epoch tag and glyph code per quantized key.
// Single port, registered read. Depends on mngm_pkg.
module mngm_cache
    import mngm_pkg::*;
#(
    parameter int CACHE_BITS = CACHE_BITS_DEF
)(
    input  logic                  clk,
    input  cache_cmd_t            cmd,
    input  logic [CACHE_BITS-1:0] addr,
    input  cache_line_t           wr_data,
    output cache_line_t           rd_data
);

    localparam int DEPTH = 1 << CACHE_BITS;

    cache_line_t mem [DEPTH];
    cache_line_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[addr] <= wr_data;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/mngm_dist.sv -----
// Distance pipeline: squared differences, pair sums, total, running minimum.
// Takes one table entry per cycle, in the cycle after its read. Depends on mngm_pkg.
module mngm_dist
    import mngm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dist_ctl_t          ctl,
    input  shape_t             query,
    input  entry_t             entry,
    output logic               done,
    output logic [GLYPH_W-1:0] code
);

    logic               v0_reg, v1_reg, v2_reg, v3_reg;
    logic               l0_reg, l1_reg, l2_reg, l3_reg;
    logic               done_reg;
    logic               have_reg;

    logic signed [COMP_W:0] diff_w [NCOMP];
    logic [COMP_W-1:0]      mag_w  [NCOMP];
    logic [SQ_W-1:0]        sq_next [NCOMP];
    logic [SQ_W-1:0]        sq_reg  [NCOMP];
    logic [PAIR_W-1:0]      pair_next [NPAIR];
    logic [PAIR_W-1:0]      pair_reg  [NPAIR];
    logic [DIST_W-1:0]      total_next;
    logic [DIST_W-1:0]      total_reg;
    logic [DIST_W-1:0]      best_dist_reg;
    logic [GLYPH_W-1:0]     c1_reg, c2_reg, c3_reg;
    logic [GLYPH_W-1:0]     best_code_reg;
    logic                   take;

    always_comb
    begin
        for (int i = 0; i < NCOMP; i++)
        begin
            diff_w[i] = $signed({query[i][COMP_W-1], query[i]})
                      - $signed({entry.comps[i][COMP_W-1], entry.comps[i]});
            mag_w[i]  = diff_w[i][COMP_W] ? COMP_W'(-diff_w[i]) : COMP_W'(diff_w[i]);
            sq_next[i] = SQ_W'(mag_w[i]) * SQ_W'(mag_w[i]);
        end
        for (int j = 0; j < NPAIR; j++)
        begin
            pair_next[j] = PAIR_W'(sq_reg[2*j]) + PAIR_W'(sq_reg[2*j+1]);
        end
        total_next = DIST_W'(pair_reg[0]) + DIST_W'(pair_reg[1]) + DIST_W'(pair_reg[2]);
    end

    // first entry always wins; later ones only when strictly closer
    assign take = !have_reg || (total_reg < best_dist_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            l0_reg   <= 1'b0;
            l1_reg   <= 1'b0;
            l2_reg   <= 1'b0;
            l3_reg   <= 1'b0;
            done_reg <= 1'b0;
            have_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= ctl.valid;
            l0_reg   <= ctl.last;
            v1_reg   <= v0_reg;
            l1_reg   <= l0_reg;
            v2_reg   <= v1_reg;
            l2_reg   <= l1_reg;
            v3_reg   <= v2_reg;
            l3_reg   <= l2_reg;
            done_reg <= v3_reg && l3_reg;
            if (ctl.clear)
            begin
                have_reg <= 1'b0;
            end
            else if (v3_reg && take)
            begin
                have_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (v0_reg)
        begin
            sq_reg <= sq_next;
            c1_reg <= entry.code;
        end
        if (v1_reg)
        begin
            pair_reg <= pair_next;
            c2_reg   <= c1_reg;
        end
        if (v2_reg)
        begin
            total_reg <= total_next;
            c3_reg    <= c2_reg;
        end
        if (ctl.clear)
        begin
            best_code_reg <= SPACE_CODE;
        end
        else if (v3_reg && take)
        begin
            best_dist_reg <= total_reg;
            best_code_reg <= c3_reg;
        end
    end

    assign done = done_reg;
    assign code = best_code_reg;

endmodule

// ----- rtl/memoized_nearest_glyph_match_top.sv -----
// Memoized nearest glyph matcher, top level: control sequencer, key quantizer,
// glyph table, answer cache and distance pipeline. Depends on mngm_pkg and all rtl modules.
//
// One item at a time. A load with an index below CHAR_COUNT writes its table entry when
// accepted. A match reads the cache through the states S_KEY, S_CRD and S_CHK and answers
// from it on a hit; a miss walks the glyph table one entry per cycle through its single
// read port and the distance pipeline (squared differences, pair sums, total, running
// minimum) and writes the answer back into the cache. Cache entries carry a 4-bit epoch
// tag, so a clear bumps the epoch instead of wiping the cache; after reset and on every
// 16th clear a clearing pass writes all 2^CACHE_BITS cache entries, one a cycle, during
// which in_ready stays low. A finished answer waits in the output register and does not
// keep the next item from being accepted. Table entries never loaded read as undefined.
module memoized_nearest_glyph_match_top
    import mngm_pkg::*;
#(
    parameter int CHAR_COUNT = CHAR_COUNT_DEF,
    parameter int CACHE_BITS = CACHE_BITS_DEF,
    parameter int LEVEL_BITS = LEVEL_BITS_DEF
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [MODE_W-1:0]         mode,
    input  logic [INDEX_W-1:0]        entry_index,
    input  logic [GLYPH_W-1:0]        glyph_code,
    input  logic signed [COMP_W-1:0]  comp0,
    input  logic signed [COMP_W-1:0]  comp1,
    input  logic signed [COMP_W-1:0]  comp2,
    input  logic signed [COMP_W-1:0]  comp3,
    input  logic signed [COMP_W-1:0]  comp4,
    input  logic signed [COMP_W-1:0]  comp5,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [GLYPH_W-1:0]        glyph,
    output logic                      from_cache
);

    localparam int TIDX_W = (CHAR_COUNT > 1) ? $clog2(CHAR_COUNT) : 1;
    localparam logic [TIDX_W-1:0]     LAST_IDX   = TIDX_W'(CHAR_COUNT - 1);
    localparam int                    QP_W       = 17 + LEVEL_BITS + 1;
    localparam logic [LEVEL_BITS-1:0] LEVELS_M1  = {LEVEL_BITS{1'b1}};
    localparam logic [CACHE_BITS-1:0] SWEEP_LAST = {CACHE_BITS{1'b1}};
    localparam logic [EPOCH_W-1:0]    EPOCH_LAST = {EPOCH_W{1'b1}};

    localparam logic [2:0] S_SWEEP = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_KEY   = 3'd2;
    localparam logic [2:0] S_CRD   = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;
    localparam logic [2:0] S_SRCH  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [EPOCH_W-1:0]    epoch_reg, epoch_next;
    logic [CACHE_BITS-1:0] sweep_reg, sweep_next;
    logic [TIDX_W-1:0]     scnt_reg, scnt_next;
    logic                  issue_done_reg, issue_done_next;
    logic [GLYPH_W-1:0]    res_glyph_reg, res_glyph_next;
    logic                  res_hit_reg, res_hit_next;
    logic                  out_valid_reg, out_valid_next;
    logic [GLYPH_W-1:0]    glyph_reg, glyph_next;
    logic                  from_cache_reg, from_cache_next;
    shape_t                query_reg, query_next;
    logic [CACHE_BITS-1:0] key_reg, key_next;

    shape_t                in_shape;
    logic                  accept;
    logic                  load_ok;
    logic                  out_load;
    logic [16:0]           clamp_w [NCOMP];
    logic [QP_W-1:0]       prod_w  [NCOMP];
    logic [KEY_MAX_W-1:0]  key_full;

    logic                  tbl_wr_en;
    entry_t                tbl_wr_data;
    logic                  tbl_rd_en;
    entry_t                tbl_rd_data;

    cache_cmd_t            cache_cmd;
    logic [CACHE_BITS-1:0] cache_addr;
    cache_line_t           cache_wdata;
    cache_line_t           cache_rdata;
    logic                  cache_hit;

    dist_ctl_t             dist_ctl;
    logic                  dist_done;
    logic [GLYPH_W-1:0]    dist_code;

    assign in_shape = {comp5, comp4, comp3, comp2, comp1, comp0};
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign load_ok  = (int'(entry_index) < CHAR_COUNT);

    assign tbl_wr_en   = accept && (mode == MODE_LOAD) && load_ok;
    assign tbl_wr_data = '{code: glyph_code, comps: in_shape};

    assign cache_hit = (cache_rdata.code != '0) && (cache_rdata.epoch == epoch_reg);

    // clamp to [0, 1.0], scale by the level count minus one, round half up
    always_comb
    begin
        key_full = '0;
        for (int i = 0; i < NCOMP; i++)
        begin
            if (query_reg[i][COMP_W-1])
            begin
                clamp_w[i] = '0;
            end
            else if (query_reg[i][16:0] > ONE_Q16)
            begin
                clamp_w[i] = ONE_Q16;
            end
            else
            begin
                clamp_w[i] = query_reg[i][16:0];
            end
            prod_w[i] = QP_W'(clamp_w[i]) * QP_W'(LEVELS_M1) + QP_W'(HALF_Q16);
            key_full[i*LEVEL_BITS +: LEVEL_BITS] = prod_w[i][16 +: LEVEL_BITS];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        epoch_next      = epoch_reg;
        sweep_next      = sweep_reg;
        scnt_next       = scnt_reg;
        issue_done_next = issue_done_reg;
        res_glyph_next  = res_glyph_reg;
        res_hit_next    = res_hit_reg;
        query_next      = query_reg;
        key_next        = key_reg;
        out_load        = 1'b0;
        tbl_rd_en       = 1'b0;
        cache_cmd       = '0;
        cache_addr      = key_reg;
        cache_wdata     = '{epoch: epoch_reg, code: dist_code};
        dist_ctl        = '0;

        case (state_reg)
            S_SWEEP:
            begin
                cache_cmd.wr = 1'b1;
                cache_addr   = sweep_reg;
                cache_wdata  = '0;
                sweep_next   = sweep_reg + 1'b1;
                if (sweep_reg == SWEEP_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_MATCH:
                        begin
                            query_next = in_shape;
                            state_next = S_KEY;
                        end
                        MODE_CLEAR:
                        begin
                            // epoch about to wrap: wipe the whole cache instead
                            if (epoch_reg == EPOCH_LAST)
                            begin
                                epoch_next = '0;
                                sweep_next = '0;
                                state_next = S_SWEEP;
                            end
                            else
                            begin
                                epoch_next = epoch_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_KEY:
            begin
                key_next   = key_full[CACHE_BITS-1:0];
                state_next = S_CRD;
            end
            S_CRD:
            begin
                cache_cmd.rd = 1'b1;
                state_next   = S_CHK;
            end
            S_CHK:
            begin
                if (cache_hit)
                begin
                    res_glyph_next = cache_rdata.code;
                    res_hit_next   = 1'b1;
                    state_next     = S_DONE;
                end
                else
                begin
                    dist_ctl.clear  = 1'b1;
                    scnt_next       = '0;
                    issue_done_next = 1'b0;
                    state_next      = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (!issue_done_reg)
                begin
                    tbl_rd_en      = 1'b1;
                    dist_ctl.valid = 1'b1;
                    dist_ctl.last  = (scnt_reg == LAST_IDX);
                    if (scnt_reg == LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        scnt_next = scnt_reg + 1'b1;
                    end
                end
                // write the answer back; the key's read finished long ago
                if (dist_done)
                begin
                    cache_cmd.wr   = 1'b1;
                    res_glyph_next = dist_code;
                    res_hit_next   = 1'b0;
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        glyph_next      = glyph_reg;
        from_cache_next = from_cache_reg;
        out_valid_next  = out_valid_reg;
        if (out_load)
        begin
            glyph_next      = res_glyph_reg;
            from_cache_next = res_hit_reg;
            out_valid_next  = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            epoch_reg      <= '0;
            sweep_reg      <= '0;
            scnt_reg       <= '0;
            issue_done_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            epoch_reg      <= epoch_next;
            sweep_reg      <= sweep_next;
            scnt_reg       <= scnt_next;
            issue_done_reg <= issue_done_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_glyph_reg  <= res_glyph_next;
        res_hit_reg    <= res_hit_next;
        glyph_reg      <= glyph_next;
        from_cache_reg <= from_cache_next;
        query_reg      <= query_next;
        key_reg        <= key_next;
    end

    assign out_valid  = out_valid_reg;
    assign glyph      = glyph_reg;
    assign from_cache = from_cache_reg;

    mngm_table #(
        .CHAR_COUNT (CHAR_COUNT)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (TIDX_W'(entry_index)),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (scnt_reg),
        .rd_data (tbl_rd_data)
    );

    mngm_cache #(
        .CACHE_BITS (CACHE_BITS)
    ) u_cache (
        .clk     (clk),
        .cmd     (cache_cmd),
        .addr    (cache_addr),
        .wr_data (cache_wdata),
        .rd_data (cache_rdata)
    );

    mngm_dist u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (dist_ctl),
        .query (query_reg),
        .entry (tbl_rd_data),
        .done  (dist_done),
        .code  (dist_code)
    );

    a_cache_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(cache_cmd.rd && cache_cmd.wr))
        else $error("cache read and write in the same cycle");

    a_cache_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        cache_cmd.wr |-> (state_reg == S_SWEEP) || (state_reg == S_SRCH && dist_done))
        else $error("cache written outside sweep or search end");

    a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK && cache_hit) |=> (res_glyph_reg != '0) && res_hit_reg)
        else $error("cache hit produced an empty answer");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result shown without finishing an item");

    a_dist_done_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        dist_done |-> (state_reg == S_SRCH) && issue_done_reg)
        else $error("search finished before all entries were issued");

endmodule
